>>> hdl/hll_riemann_flux_macros.svh
// ----------------------------------------------------------------------------
// hll riemann flux assertion macros
// shared check forms for the flux block
// ----------------------------------------------------------------------------
`ifndef HLL_RIEMANN_FLUX_MACROS_SVH
`define HLL_RIEMANN_FLUX_MACROS_SVH

// same-cycle implication
`define HLLR_CHECK(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HLLR_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/hllr_pkg.sv
// ----------------------------------------------------------------------------
// hllr_pkg
// widths and the word type passed along the divider chain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hllr_pkg;

   localparam int FRAC_BITS = 16;
   localparam int VAL_W     = 32;
   localparam int DV_W      = 32 + FRAC_BITS;
   localparam int N2_W      = 65;
   localparam int N3_W      = 96;
   localparam int T_W       = ((N2_W + FRAC_BITS > N3_W) ? N2_W + FRAC_BITS : N3_W) + 1;
   localparam int Q_W       = 33;

   typedef struct packed {
      logic              valid;
      logic              bypass;
      logic [VAL_W-1:0]  byp_val;
      logic              neg;
      logic              ovf;
      logic [DV_W-1:0]   dv;
      logic [DV_W-1:0]   rem;
      logic [Q_W-1:0]    low;
   } div_word_type;

endpackage

>>> hdl/hllr_front.sv
// ----------------------------------------------------------------------------
// hllr_front
// upwind select, products and exact numerator, feeding the divider chain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hllr_front
   import hllr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  logic signed [VAL_W-1:0]  speed_left,
   input  logic signed [VAL_W-1:0]  speed_right,
   input  logic signed [VAL_W-1:0]  flux_left,
   input  logic signed [VAL_W-1:0]  flux_right,
   input  logic signed [VAL_W-1:0]  state_left,
   input  logic signed [VAL_W-1:0]  state_right,
   output div_word_type             out_word
);

   // stage 1
   logic                v1_ff, byp1_ff;
   logic [VAL_W-1:0]    bv1_ff;
   logic signed [63:0]  pa1_ff, pb1_ff, ss1_ff;
   logic signed [32:0]  du1_ff;
   logic [31:0]         den1_ff;
   // stage 2
   logic                v2_ff, byp2_ff, neg3_2_ff;
   logic [VAL_W-1:0]    bv2_ff;
   logic signed [N2_W-1:0] n2_2_ff;
   logic [62:0]         ssm2_ff;
   logic [31:0]         dum2_ff, den2_ff;
   // stage 3
   logic                v3_ff, byp3_ff, neg3_3_ff;
   logic [VAL_W-1:0]    bv3_ff;
   logic signed [N2_W-1:0] n2_3_ff;
   logic [63:0]         pplo3_ff;
   logic [62:0]         pphi3_ff;
   logic [31:0]         den3_ff;
   // stage 4
   logic                v4_ff, byp4_ff, neg3_4_ff;
   logic [VAL_W-1:0]    bv4_ff;
   logic [T_W-1:0]      n2s4_ff;
   logic [N3_W-1:0]     n3m4_ff;
   logic [31:0]         den4_ff;
   // stage 5
   logic                v5_ff, byp5_ff;
   logic [VAL_W-1:0]    bv5_ff;
   logic [T_W-1:0]      n2s5_ff, n3s5_ff;
   logic [31:0]         den5_ff;
   // stage 6
   logic                v6_ff, byp6_ff;
   logic [VAL_W-1:0]    bv6_ff;
   logic [T_W-1:0]      t6_ff;
   logic [31:0]         den6_ff;
   // stage 7
   logic                v7_ff, byp7_ff, neg7_ff;
   logic [VAL_W-1:0]    bv7_ff;
   logic [T_W-1:0]      tm7_ff;
   logic [31:0]         den7_ff;
   // stage 8
   div_word_type        w8_ff, w8_in;

   logic [N3_W-1:0]     n3m_in;
   logic [T_W-1:0]      n3m_ext, n2_ext;
   logic [T_W-Q_W-1:0]  t_hi;
   logic [DV_W-1:0]     dv7;

   assign n3m_in     = {1'b0, pphi3_ff, 32'b0} + {32'b0, pplo3_ff};
   assign n3m_ext    = {{(T_W-N3_W){1'b0}}, n3m4_ff};
   assign n2_ext     = {{(T_W-N2_W){n2_3_ff[N2_W-1]}}, n2_3_ff};
   assign dv7        = {den7_ff, {FRAC_BITS{1'b0}}};
   assign t_hi       = tm7_ff[T_W-1:Q_W];

   always_comb begin
      w8_in         = '0;
      w8_in.valid   = v7_ff;
      w8_in.bypass  = byp7_ff;
      w8_in.byp_val = bv7_ff;
      w8_in.neg     = neg7_ff;
      w8_in.dv      = dv7;
      w8_in.ovf     = t_hi >= {{(T_W-Q_W-DV_W){1'b0}}, dv7};
      w8_in.rem     = t_hi[DV_W-1:0];
      w8_in.low     = tm7_ff[Q_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
         v5_ff <= 1'b0; v6_ff <= 1'b0; v7_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
         v5_ff <= v4_ff; v6_ff <= v5_ff; v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         // upwind select and products
         byp1_ff <= !speed_left[VAL_W-1] || (speed_right <= 0);
         bv1_ff  <= !speed_left[VAL_W-1] ? flux_left : flux_right;
         pa1_ff  <= 64'(speed_right) * 64'(flux_left);
         pb1_ff  <= 64'(speed_left) * 64'(flux_right);
         ss1_ff  <= 64'(speed_right) * 64'(speed_left);
         du1_ff  <= $signed({state_right[VAL_W-1], state_right})
                    - $signed({state_left[VAL_W-1], state_left});
         den1_ff <= 32'(speed_right - speed_left);
         // magnitudes
         byp2_ff   <= byp1_ff;
         bv2_ff    <= bv1_ff;
         den2_ff   <= den1_ff;
         n2_2_ff   <= $signed({pa1_ff[63], pa1_ff}) - $signed({pb1_ff[63], pb1_ff});
         ssm2_ff   <= ss1_ff[63] ? 63'(-ss1_ff) : ss1_ff[62:0];
         dum2_ff   <= du1_ff[32] ? 32'(-du1_ff) : du1_ff[31:0];
         neg3_2_ff <= ss1_ff[63] != du1_ff[32];
         // split product of speeds and state jump
         byp3_ff   <= byp2_ff;
         bv3_ff    <= bv2_ff;
         den3_ff   <= den2_ff;
         n2_3_ff   <= n2_2_ff;
         neg3_3_ff <= neg3_2_ff;
         pplo3_ff  <= 64'(ssm2_ff[31:0]) * 64'(dum2_ff);
         pphi3_ff  <= 63'(ssm2_ff[62:32]) * 63'(dum2_ff);
         // partial product sum
         byp4_ff   <= byp3_ff;
         bv4_ff    <= bv3_ff;
         den4_ff   <= den3_ff;
         neg3_4_ff <= neg3_3_ff;
         n3m4_ff   <= n3m_in;
         n2s4_ff   <= n2_ext << FRAC_BITS;
         // signed term
         byp5_ff <= byp4_ff;
         bv5_ff  <= bv4_ff;
         den5_ff <= den4_ff;
         n2s5_ff <= n2s4_ff;
         n3s5_ff <= neg3_4_ff ? (~n3m_ext + 1'b1) : n3m_ext;
         // numerator
         byp6_ff <= byp5_ff;
         bv6_ff  <= bv5_ff;
         den6_ff <= den5_ff;
         t6_ff   <= n2s5_ff + n3s5_ff;
         // magnitude of numerator
         byp7_ff <= byp6_ff;
         bv7_ff  <= bv6_ff;
         den7_ff <= den6_ff;
         neg7_ff <= t6_ff[T_W-1];
         tm7_ff  <= t6_ff[T_W-1] ? (~t6_ff + 1'b1) : t6_ff;
      end
   end

   // overflow check and divider seed
   always_ff @(posedge clock) begin
      if (reset) begin
         w8_ff.valid <= 1'b0;
      end else if (advance) begin
         w8_ff.valid <= w8_in.valid;
      end
      if (advance) begin
         w8_ff.bypass  <= w8_in.bypass;
         w8_ff.byp_val <= w8_in.byp_val;
         w8_ff.neg     <= w8_in.neg;
         w8_ff.ovf     <= w8_in.ovf;
         w8_ff.dv      <= w8_in.dv;
         w8_ff.rem     <= w8_in.rem;
         w8_ff.low     <= w8_in.low;
      end
   end

   assign out_word = w8_ff;

endmodule

>>> hdl/hllr_div_cell.sv
// ----------------------------------------------------------------------------
// hllr_div_cell
// one restoring division step, one quotient bit per cell
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hllr_div_cell
   import hllr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  div_word_type  in_word,
   output div_word_type  out_word
);

   div_word_type     word_ff, word_in;
   logic [DV_W:0]    trial;
   logic             fits;

   assign trial = {in_word.rem, in_word.low[Q_W-1]};
   assign fits  = trial >= {1'b0, in_word.dv};

   always_comb begin
      word_in     = in_word;
      word_in.rem = fits ? DV_W'(trial - {1'b0, in_word.dv}) : trial[DV_W-1:0];
      word_in.low = {in_word.low[Q_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (advance) begin
         word_ff.valid <= word_in.valid;
      end
      if (advance) begin
         word_ff.bypass  <= word_in.bypass;
         word_ff.byp_val <= word_in.byp_val;
         word_ff.neg     <= word_in.neg;
         word_ff.ovf     <= word_in.ovf;
         word_ff.dv      <= word_in.dv;
         word_ff.rem     <= word_in.rem;
         word_ff.low     <= word_in.low;
      end
   end

   assign out_word = word_ff;

endmodule

>>> hdl/hll_riemann_flux.sv
// ----------------------------------------------------------------------------
// hll_riemann_flux
// hll face flux in signed fixed point, one face word per cycle
//
//  channel | dir | ports                                   | handshake
//  req     | in  | speed/flux/state left and right         | req_valid, req_stall
//  rsp     | out | face_flux, saturated                    | rsp_valid, rsp_stall
//
//  pipeline: 8 front stages, 33 division cells, 1 output register
//  one word accepted every cycle while the result side takes words
//  the whole chain holds while a result waits under rsp_stall
//  synchronous reset clears the valid bits only
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "hll_riemann_flux_macros.svh"

module hll_riemann_flux
   import hllr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [VAL_W-1:0]  req_speed_left,
   input  logic signed [VAL_W-1:0]  req_speed_right,
   input  logic signed [VAL_W-1:0]  req_flux_left,
   input  logic signed [VAL_W-1:0]  req_flux_right,
   input  logic signed [VAL_W-1:0]  req_state_left,
   input  logic signed [VAL_W-1:0]  req_state_right,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [VAL_W-1:0]  rsp_face_flux,
   output logic                     rsp_saturated
);

   localparam int N_CELLS = Q_W;

   div_word_type       chain [N_CELLS+1];
   logic               advance;
   logic               valid_ff;
   logic [VAL_W-1:0]   flux_ff, flux_in;
   logic               sat_ff, sat_in;
   div_word_type       last;
   logic [Q_W-1:0]     limit;

   assign advance   = !(valid_ff && rsp_stall);
   assign req_stall = !advance;

   hllr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_valid),
      .speed_left  (req_speed_left),
      .speed_right (req_speed_right),
      .flux_left   (req_flux_left),
      .flux_right  (req_flux_right),
      .state_left  (req_state_left),
      .state_right (req_state_right),
      .out_word    (chain[0])
   );

   for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
      hllr_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_word  (chain[i]),
         .out_word (chain[i+1])
      );
   end

   assign last  = chain[N_CELLS];
   assign limit = last.neg ? Q_W'(33'h080000000) : Q_W'(33'h07FFFFFFF);

   always_comb begin
      sat_in  = 1'b0;
      flux_in = last.byp_val;
      if (!last.bypass) begin
         sat_in = last.ovf || (last.low > limit);
         if (sat_in) begin
            flux_in = last.neg ? 32'h80000000 : 32'h7FFFFFFF;
         end else begin
            flux_in = last.neg ? 32'(-last.low[VAL_W-1:0]) : last.low[VAL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         flux_ff <= flux_in;
         sat_ff  <= sat_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_face_flux = flux_ff;
   assign rsp_saturated = sat_ff;

   `HLLR_CHECK(a_stall_only_on_held, req_stall, rsp_valid && rsp_stall, "stall without held word")
   `HLLR_CHECK(a_sat_clamped, rsp_valid && rsp_saturated,
      rsp_face_flux == 32'sh7FFFFFFF || rsp_face_flux == 32'sh80000000, "saturated but not clamped")
   `HLLR_CHECK_NEXT(a_enter, req_valid && !req_stall, u_front.v1_ff, "accepted word lost")
   `HLLR_CHECK_NEXT(a_out_take, last.valid && advance, rsp_valid, "result word lost")

endmodule

>>> sim/hll_riemann_flux_tb.sv
// ----------------------------------------------------------------------------
// hll_riemann_flux_tb
// self-checking bench for the hll face flux block: directed faces covering
// both upwind cases, the mixed case, saturation and field extremes, then
// random faces, with random idling on both channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hll_riemann_flux_tb
   import hllr_pkg::*;
();

   typedef struct {
      logic signed [VAL_W-1:0] sl, sr, fl, fr, ul, ur;
   } face_type;

   typedef struct {
      logic signed [VAL_W-1:0] flux;
      logic                    sat;
   } flux_type;

   class flux_scoreboard;
      flux_type pending[$];
      int       n_bad;
      int       n_checked;

      function flux_type hll_flux(face_type f);
         flux_type        r;
         logic signed [63:0]  sl, sr, fl, fr, ul, ur, den;
         logic signed [159:0] num, q, dvs;
         sl = 64'(f.sl); sr = 64'(f.sr); fl = 64'(f.fl); fr = 64'(f.fr);
         ul = 64'(f.ul); ur = 64'(f.ur);
         r.sat = 1'b0;
         r.flux = '0;
         if (sl >= 0) begin
            r.flux = f.fl;
         end else if (sr <= 0) begin
            r.flux = f.fr;
         end else begin
            den = sr - sl;
            if (den != 0) begin
               num = ((160'(sr) * 160'(fl)) - (160'(sl) * 160'(fr))) <<< FRAC_BITS;
               num = num + 160'(sr) * 160'(sl) * (160'(ur) - 160'(ul));
               dvs = 160'(den) <<< FRAC_BITS;
               q = num / dvs;
               if (q > 160'sh7FFFFFFF) begin
                  q = 160'sh7FFFFFFF;
                  r.sat = 1'b1;
               end else if (q < -160'sh80000000) begin
                  q = -160'sh80000000;
                  r.sat = 1'b1;
               end
               r.flux = q[31:0];
            end
         end
         return r;
      endfunction

      function void note_face(face_type f);
         pending.push_back(hll_flux(f));
      endfunction

      function void check_flux(logic [31:0] flux, logic sat);
         flux_type e;
         n_checked++;
         if (pending.size() == 0) begin
            n_bad++;
            if (n_bad <= 10) $display("unexpected word: flux %h sat %b", flux, sat);
            return;
         end
         e = pending.pop_front();
         if (e.flux !== flux || e.sat !== sat) begin
            n_bad++;
            if (n_bad <= 10)
               $display("mismatch: expected flux %h sat %b, got flux %h sat %b",
                        e.flux, e.sat, flux, sat);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [VAL_W-1:0] req_speed_left = '0, req_speed_right = '0;
   logic signed [VAL_W-1:0] req_flux_left = '0, req_flux_right = '0;
   logic signed [VAL_W-1:0] req_state_left = '0, req_state_right = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [VAL_W-1:0] rsp_face_flux;
   logic rsp_saturated;

   flux_scoreboard sb = new();
   bit quiet = 1'b0;
   int n_mixed = 0, n_upwind = 0;

   always #10 clock = ~clock;

   hll_riemann_flux DUT (.*);

   // result side: check accepted words, stall in bursts
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_flux(rsp_face_flux, rsp_saturated);
      end
   end

   initial begin : stall_gen
      int n;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 10);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic [31:0] rand_val();
      case ($urandom_range(0, 5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return $urandom_range(0, 3);
         3: return 32'(int'($urandom_range(0, 32'h60000)) - 32'h30000);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_face(face_type f);
      req_valid <= 1'b1;
      req_speed_left <= f.sl; req_speed_right <= f.sr;
      req_flux_left <= f.fl;  req_flux_right <= f.fr;
      req_state_left <= f.ul; req_state_right <= f.ur;
      do @(posedge clock); while (req_stall);
      sb.note_face(f);
      if (f.sl < 0 && f.sr > 0) n_mixed++; else n_upwind++;
   endtask

   task automatic idle_gap();
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   initial begin : stimulus
      face_type f;
      face_type dir[$];
      int wait_cyc;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // upwind left, upwind right, zero speeds
      dir.push_back('{32'sh10000, 32'sh20000, 32'sh12345, 32'sh54321, 1, 2});
      dir.push_back('{0, 0, 32'sh7FFFFFFF, 32'sh80000000, 0, 0});
      dir.push_back('{-1, 0, 32'sh7FFFFFFF, 32'sh80000000, 0, 0});
      dir.push_back('{32'sh80000000, 32'sh80000000, 5, -5, 0, 0});
      dir.push_back('{32'sh7FFFFFFF, 32'sh7FFFFFFF, -7, 7, 0, 0});
      // mixed, ordinary and smallest denominator
      dir.push_back('{-32'sh10000, 32'sh10000, 32'sh20000, 32'sh30000, 0, 32'sh10000});
      dir.push_back('{-1, 1, 32'sh10000, -32'sh10000, 32'sh10000, -32'sh10000});
      // mixed, extremes and saturation both ways
      dir.push_back('{32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
                      32'sh80000000, 32'sh7FFFFFFF});
      dir.push_back('{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                      32'sh7FFFFFFF, 32'sh80000000});
      dir.push_back('{-1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0, 32'sh7FFFFFFF});
      dir.push_back('{32'sh80000000, 1, 0, 32'sh80000000, 32'sh80000000, 0});
      dir.push_back('{-32'sh8000, 32'sh8000, -1, -1, -1, -1});
      dir.push_back('{-32'sh30000, 32'sh10000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0});
      foreach (dir[i]) begin
         send_face(dir[i]);
         idle_gap();
      end

      for (int i = 0; i < 1300; i++) begin
         if (i == 1100) quiet = 1'b1;
         f.sl = rand_val(); f.sr = rand_val();
         // mostly mixed faces, where the division path lives
         if ($urandom_range(0, 3) != 0) begin
            if (f.sl >= 0) f.sl = ~f.sl;
            if (f.sr <= 0) f.sr = ~f.sr;
         end
         f.fl = rand_val(); f.fr = rand_val();
         f.ul = rand_val(); f.ur = rand_val();
         send_face(f);
         idle_gap();
      end
      req_valid <= 1'b0;

      wait_cyc = 0;
      while (sb.pending.size() != 0 && wait_cyc < 100000) begin
         @(posedge clock);
         wait_cyc++;
      end
      repeat (60) @(posedge clock);
      $display("faces sent: %0d mixed, %0d upwind; %0d results checked",
               n_mixed, n_upwind, sb.n_checked);
      if (sb.n_bad == 0 && sb.pending.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.n_bad, sb.pending.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #2ms;
      $display("timeout");
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> hll_riemann_flux.f
+incdir+hdl
hdl/hllr_pkg.sv
hdl/hllr_front.sv
hdl/hllr_div_cell.sv
hdl/hll_riemann_flux.sv
sim/hll_riemann_flux_tb.sv
